### hw/rtl/scc_pkg.sv
// Shared types, constants and command tables for the serial camera capture sequencer.
// Used by scc_ctrl, scc_emit and serial_camera_capture_sequencer.
`default_nettype none

package scc_pkg;

    // Default number of size-query reply bytes captured before the image read
    localparam int SIZE_REPLY_LEN_DEF = 9;

    // Positions of the image length bytes in the size-query reply
    localparam int LEN_HI_POS = 7;
    localparam int LEN_LO_POS = 8;

    // Bytes the sequencer reacts to
    localparam logic [7:0] JPEG_START   = 8'hff;
    localparam logic [7:0] JPEG_END_HI  = 8'hd9;
    localparam logic [7:0] JPEG_END_LO  = 8'h76;

    // Command bytes
    localparam logic [7:0] CAM_SYNC     = 8'h56;
    localparam logic [7:0] CAM_ZERO     = 8'h00;
    localparam logic [7:0] CAM_CTRL     = 8'h36;
    localparam logic [7:0] CAM_SIZE     = 8'h34;
    localparam logic [7:0] CAM_READ     = 8'h32;
    localparam logic [7:0] CAM_ONE      = 8'h01;
    localparam logic [7:0] CAM_STOP     = 8'h03;
    localparam logic [7:0] CAM_READ_LEN = 8'h0c;
    localparam logic [7:0] CAM_DELAY    = 8'h0A;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TRIGGER = 1'b1;

    localparam logic DEST_CAMERA = 1'b0;
    localparam logic DEST_HOST   = 1'b1;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_IDLE = 2'd1,
        PH_SHOT = 2'd2,
        PH_SIZE = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_IDLE,
        CMD_SHOT,
        CMD_SIZE,
        CMD_READ
    } t_cmd;

    // Work handed from the control logic to the output sequencer
    typedef struct packed {
        logic       fwd;
        logic [7:0] fwd_byte;
        t_cmd       cmd;
        logic [7:0] len_hi;
        logic [7:0] len_lo;
    } t_job;

    function automatic logic [4:0] cmd_length(input t_cmd cmd);
        case (cmd)
            CMD_IDLE, CMD_SHOT, CMD_SIZE: cmd_length = 5'd5;
            CMD_READ:                     cmd_length = 5'd16;
            default:                      cmd_length = 5'd0;
        endcase
    endfunction

    function automatic logic [7:0] cmd_byte(input t_cmd cmd, input logic [3:0] idx,
                                            input logic [7:0] len_hi,
                                            input logic [7:0] len_lo);
        logic [7:0] b;
        b = CAM_ZERO;
        case (idx)
            4'd0: b = CAM_SYNC;
            4'd1: b = CAM_ZERO;
            4'd2: begin
                case (cmd)
                    CMD_SIZE: b = CAM_SIZE;
                    CMD_READ: b = CAM_READ;
                    default:  b = CAM_CTRL;
                endcase
            end
            4'd3: b = (cmd == CMD_READ) ? CAM_READ_LEN : CAM_ONE;
            4'd4: b = (cmd == CMD_IDLE) ? CAM_STOP : CAM_ZERO;
            4'd5: b = CAM_DELAY;
            4'd12: b = len_hi;
            4'd13: b = len_lo;
            4'd15: b = CAM_DELAY;
            default: b = CAM_ZERO;
        endcase
        cmd_byte = b;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/scc_ctrl.sv
// Sequencer state: reply counters, capture of the length bytes, image marker tracking.
// Builds one job per accepted transfer. Depends on scc_pkg.
`default_nettype none

module scc_ctrl #(
    parameter int SIZE_REPLY_LEN = scc_pkg::SIZE_REPLY_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    output scc_pkg::t_job    o_job
);
    import scc_pkg::*;

    localparam int CW = $clog2(SIZE_REPLY_LEN + 1);

    t_phase        r_phase,    n_phase;
    logic [1:0]    r_idle,     n_idle;
    logic [2:0]    r_shot,     n_shot;
    logic [CW-1:0] r_size,     n_size;
    logic          r_armed,    n_armed;
    logic [CW-1:0] r_cap_idx,  n_cap_idx;
    logic [7:0]    r_len_hi,   n_len_hi;
    logic [7:0]    r_len_lo,   n_len_lo;
    logic          r_reading,  n_reading;
    logic          r_started,  n_started;
    logic          r_saw_end,  n_saw_end;

    always_comb begin
        n_phase   = r_phase;
        n_idle    = r_idle;
        n_shot    = r_shot;
        n_size    = r_size;
        n_armed   = r_armed;
        n_cap_idx = r_cap_idx;
        n_len_hi  = r_len_hi;
        n_len_lo  = r_len_lo;
        n_reading = r_reading;
        n_started = r_started;
        n_saw_end = r_saw_end;

        o_job          = '0;
        o_job.cmd      = CMD_NONE;
        o_job.fwd_byte = i_rx_byte;

        if (i_req_type == REQ_TRIGGER) begin
            n_len_hi  = '0;
            n_len_lo  = '0;
            n_phase   = PH_IDLE;
            n_idle    = '0;
            n_cap_idx = '0;
            n_reading = 1'b0;
            n_started = 1'b0;
            o_job.cmd = CMD_IDLE;
        end else begin
            // count the reply against the pending command
            if (r_phase == PH_IDLE && r_idle < 2'd3) begin
                n_idle = r_idle + 2'd1;
            end else if (r_phase == PH_SHOT && r_shot < 3'd5) begin
                n_shot = r_shot + 3'd1;
            end else if (r_phase == PH_SIZE && r_size < CW'(SIZE_REPLY_LEN)) begin
                n_size = r_size + CW'(1);
            end

            // capture, keeping only the length bytes
            if (r_armed && r_cap_idx < CW'(SIZE_REPLY_LEN)) begin
                if (r_cap_idx == CW'(LEN_HI_POS)) begin
                    n_len_hi = i_rx_byte;
                end
                if (r_cap_idx == CW'(LEN_LO_POS)) begin
                    n_len_lo = i_rx_byte;
                end
                n_cap_idx = r_cap_idx + CW'(1);
            end

            if (i_rx_byte == JPEG_START) begin
                n_started = 1'b1;
            end

            if (i_rx_byte == JPEG_END_HI) begin
                n_saw_end = 1'b1;
            end else if (i_rx_byte == JPEG_END_LO && r_saw_end) begin
                n_started = 1'b0;
                n_saw_end = 1'b0;
                n_len_hi  = '0;
                n_len_lo  = '0;
            end else begin
                n_saw_end = 1'b0;
            end

            o_job.fwd = r_reading && n_started;

            if (n_idle >= 2'd3) begin
                n_phase   = PH_SHOT;
                n_idle    = '0;
                n_shot    = '0;
                n_cap_idx = '0;
                o_job.cmd = CMD_SHOT;
            end else if (n_shot == 3'd5) begin
                n_phase   = PH_SIZE;
                n_shot    = '0;
                n_size    = '0;
                n_armed   = 1'b1;
                o_job.cmd = CMD_SIZE;
            end else if (n_size == CW'(SIZE_REPLY_LEN)) begin
                n_size    = '0;
                n_phase   = PH_NONE;
                n_armed   = 1'b0;
                n_reading = 1'b1;
                n_started = 1'b0;
                n_cap_idx = '0;
                o_job.cmd = CMD_READ;
            end
        end

        o_job.len_hi = n_len_hi;
        o_job.len_lo = n_len_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_NONE;
            r_idle    <= '0;
            r_shot    <= '0;
            r_size    <= '0;
            r_armed   <= 1'b0;
            r_cap_idx <= '0;
            r_len_hi  <= '0;
            r_len_lo  <= '0;
            r_reading <= 1'b0;
            r_started <= 1'b0;
            r_saw_end <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_idle    <= n_idle;
            r_shot    <= n_shot;
            r_size    <= n_size;
            r_armed   <= n_armed;
            r_cap_idx <= n_cap_idx;
            r_len_hi  <= n_len_hi;
            r_len_lo  <= n_len_lo;
            r_reading <= n_reading;
            r_started <= n_started;
            r_saw_end <= n_saw_end;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/scc_emit.sv
// Output sequencer: plays one job out as a run of transfers through the output register.
// Depends on scc_pkg.
`default_nettype none

module scc_emit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire scc_pkg::t_job i_job,
    output logic             o_free,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_dest,
    output logic [7:0]       o_out_byte,
    output logic             o_last
);
    import scc_pkg::*;

    logic       r_fwd_pend;
    logic [7:0] r_fwd_byte;
    t_cmd       r_cmd;
    logic [3:0] r_cidx;
    logic [7:0] r_len_hi;
    logic [7:0] r_len_lo;

    logic       r_valid;
    logic       r_dest;
    logic [7:0] r_byte;
    logic       r_last;

    logic       busy;
    logic       adv;
    logic       last_now;
    logic [4:0] cmd_len;

    assign cmd_len  = cmd_length(r_cmd);
    assign busy     = r_fwd_pend || (r_cmd != CMD_NONE);
    assign adv      = busy && (!r_valid || !i_out_stall);
    assign last_now = r_fwd_pend ? (r_cmd == CMD_NONE)
                                 : ({1'b0, r_cidx} == cmd_len - 5'd1);
    assign o_free   = !busy || (adv && last_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_pend <= 1'b0;
            r_cmd      <= CMD_NONE;
            r_cidx     <= '0;
        end else if (i_load) begin
            r_fwd_pend <= i_job.fwd;
            r_cmd      <= i_job.cmd;
            r_cidx     <= '0;
        end else if (adv) begin
            if (last_now) begin
                r_fwd_pend <= 1'b0;
                r_cmd      <= CMD_NONE;
            end else if (r_fwd_pend) begin
                r_fwd_pend <= 1'b0;
            end else begin
                r_cidx <= r_cidx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fwd_byte <= i_job.fwd_byte;
            r_len_hi   <= i_job.len_hi;
            r_len_lo   <= i_job.len_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dest <= r_fwd_pend ? DEST_HOST : DEST_CAMERA;
            r_byte <= r_fwd_pend ? r_fwd_byte
                                 : cmd_byte(r_cmd, r_cidx, r_len_hi, r_len_lo);
            r_last <= last_now;
        end
    end

    assign o_out_valid = r_valid;
    assign o_dest      = r_dest;
    assign o_out_byte  = r_byte;
    assign o_last      = r_last;

endmodule

`default_nettype wire

### hw/rtl/serial_camera_capture_sequencer.sv
// Serial camera capture sequencer, top level. The first result of a transfer goes from
// the job registers of the output sequencer into its output register. A transfer has N
// results (0 to 17); the output sequencer sends one byte a cycle while not stalled.
// Reset is synchronous, active low: all counters, flags and phases and the length bytes
// held in scc_ctrl clear; the byte copies in scc_emit and its output bytes do not.
// Depends on scc_pkg, scc_ctrl and scc_emit.
`default_nettype none

module serial_camera_capture_sequencer #(
    parameter int SIZE_REPLY_LEN = scc_pkg::SIZE_REPLY_LEN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    // camera bytes and trigger requests
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_rx_byte,

    // bytes for the camera or the host
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_dest,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);
    import scc_pkg::*;

    logic accept;
    logic emit_free;
    t_job job;

    // Take a new transfer once the sequencer is empty or is sending its final byte this
    // cycle; a downstream stall on the byte in the output register holds the input as well.
    assign o_in_stall = !emit_free;
    assign accept     = i_in_valid && !o_in_stall;

    // Update all counters and flags in the cycle of acceptance and describe what to send
    scc_ctrl #(
        .SIZE_REPLY_LEN (SIZE_REPLY_LEN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .o_job      (job)
    );

    // Play the forwarded byte first, then the command bytes, one transfer a cycle while not stalled
    scc_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_job       (job),
        .o_free      (emit_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dest      (o_dest),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

### verif/serial_camera_capture_sequencer_tb.sv
// Self-checking testbench for serial_camera_capture_sequencer: triggers and camera bytes go in,
// and every byte for the camera or the host is checked against a predictor held here.
// Depends on scc_pkg and the serial_camera_capture_sequencer RTL.

module serial_camera_capture_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scc_pkg::*;

    localparam int SIZE_REPLY_LEN = SIZE_REPLY_LEN_DEF;
    localparam int IDLE_REPLIES   = 3;
    localparam int SHOT_REPLIES   = 5;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int N_DIRECTED     = 25;

    // One byte on the output channel
    typedef struct packed {
        logic       dest;
        logic [7:0] data;
        logic       last;
    } t_tx;

    // One row of the directed table; typed rows carry the result count and the final byte
    typedef struct packed {
        logic       req;
        logic [7:0] rx;
        logic       typed;
        logic [4:0] cnt;
        logic       dest;
        logic [7:0] tail;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_req_type;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_dest;
    logic [7:0] o_out_byte;
    logic       o_last;

    serial_camera_capture_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dest      (o_dest),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    // Predictor state: a private copy of the sequencer's counters and stored reply bytes
    t_phase     cam_phase;
    logic [1:0] idle_reply_count;
    logic [2:0] shot_reply_count;
    logic [3:0] size_cnt;
    logic       capture_on;
    logic [3:0] capture_pos;
    logic [7:0] size_reply [SIZE_REPLY_LEN];
    logic       image_read_on;
    logic       image_open;
    logic       end_hi_seen;

    t_tx step_bytes [$];      // bytes caused by the transfer being predicted
    t_tx expected_tx [$];     // bytes still owed by the block, oldest first

    int unsigned items_sent;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned rx_stall_pct;
    int unsigned hold_left;
    bit          hold_req;
    bit          hold_ack;

    // Directed table: idle bytes after reset, a full capture sequence with the length
    // bytes set, then image data through the end marker
    t_row directed_rows [N_DIRECTED] = '{
        '{REQ_BYTE,    8'h00, 1'b1, 5'd0,  DEST_CAMERA, 8'h00},  // nothing pending
        '{REQ_BYTE,    8'hff, 1'b1, 5'd0,  DEST_CAMERA, 8'h00},  // start byte, no read active
        '{REQ_TRIGGER, 8'hff, 1'b1, 5'd5,  DEST_CAMERA, CAM_STOP},
        '{REQ_BYTE,    8'h76, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h00, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h36, 1'b1, 5'd5,  DEST_CAMERA, CAM_ZERO},  // third idle reply
        '{REQ_BYTE,    8'h76, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h00, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h36, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h00, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h00, 1'b1, 5'd5,  DEST_CAMERA, CAM_ZERO},  // fifth shot reply
        '{REQ_BYTE,    8'h76, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h00, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h34, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h00, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h04, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h00, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h00, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},
        '{REQ_BYTE,    8'h12, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},  // length high
        '{REQ_BYTE,    8'hab, 1'b1, 5'd16, DEST_CAMERA, CAM_DELAY},  // length low, read sent
        '{REQ_BYTE,    8'h12, 1'b0, 5'd0,  DEST_CAMERA, 8'h00},  // before the start byte
        '{REQ_BYTE,    8'hff, 1'b1, 5'd1,  DEST_HOST,   8'hff},
        '{REQ_BYTE,    8'hd9, 1'b1, 5'd1,  DEST_HOST,   8'hd9},
        '{REQ_BYTE,    8'h76, 1'b1, 5'd0,  DEST_CAMERA, 8'h00},  // end marker swallowed
        '{REQ_BYTE,    8'h55, 1'b0, 5'd0,  DEST_CAMERA, 8'h00}
    };

    // Clock: 12 ns period
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %02h expected %02h",
                 cycle_count, what, got, want);
    endtask

    function automatic void push_tx(input logic dest, input logic [7:0] data);
        step_bytes.push_back('{dest: dest, data: data, last: 1'b0});
    endfunction

    // Idle, shot and size query differ only in their third and fifth bytes
    function automatic void push_short_cmd(input logic [7:0] op, input logic [7:0] arg);
        push_tx(DEST_CAMERA, CAM_SYNC);
        push_tx(DEST_CAMERA, CAM_ZERO);
        push_tx(DEST_CAMERA, op);
        push_tx(DEST_CAMERA, CAM_ONE);
        push_tx(DEST_CAMERA, arg);
    endfunction

    function automatic void clear_size_reply();
        foreach (size_reply[k]) size_reply[k] = 8'h00;
    endfunction

    // Advance the predictor by one accepted transfer and leave its bytes in step_bytes
    function automatic void sequencer_step(input logic req, input logic [7:0] rx);
        step_bytes.delete();
        if (req == REQ_TRIGGER) begin
            // restart at the idle command; capture arming and the later counters survive
            clear_size_reply();
            cam_phase        = PH_IDLE;
            idle_reply_count = '0;
            capture_pos      = '0;
            image_read_on    = 1'b0;
            image_open       = 1'b0;
            push_short_cmd(CAM_CTRL, CAM_STOP);
        end else begin
            // count the reply against the pending command
            if (cam_phase == PH_IDLE && idle_reply_count < IDLE_REPLIES)
                idle_reply_count++;
            else if (cam_phase == PH_SHOT && shot_reply_count < SHOT_REPLIES)
                shot_reply_count++;
            else if (cam_phase == PH_SIZE && size_cnt < SIZE_REPLY_LEN)
                size_cnt++;

            // store while armed; drop bytes once the store is full
            if (capture_on && capture_pos < SIZE_REPLY_LEN) begin
                size_reply[capture_pos] = rx;
                capture_pos++;
            end

            if (rx == JPEG_START)
                image_open = 1'b1;

            if (rx == JPEG_END_HI) begin
                end_hi_seen = 1'b1;
            end else if (rx == JPEG_END_LO && end_hi_seen) begin
                image_open  = 1'b0;
                end_hi_seen = 1'b0;
                clear_size_reply();
            end else begin
                end_hi_seen = 1'b0;
            end

            if (image_read_on && image_open)
                push_tx(DEST_HOST, rx);

            // at most one follow-on command per byte: idle, then shot, then size order
            if (idle_reply_count >= IDLE_REPLIES) begin
                cam_phase        = PH_SHOT;
                idle_reply_count = '0;
                shot_reply_count = '0;
                capture_pos      = '0;
                push_short_cmd(CAM_CTRL, CAM_ZERO);
            end else if (shot_reply_count == SHOT_REPLIES) begin
                cam_phase        = PH_SIZE;
                shot_reply_count = '0;
                size_cnt         = '0;
                capture_on       = 1'b1;
                push_short_cmd(CAM_SIZE, CAM_ZERO);
            end else if (size_cnt == SIZE_REPLY_LEN) begin
                size_cnt      = '0;
                cam_phase     = PH_NONE;
                capture_on    = 1'b0;
                image_read_on = 1'b1;
                image_open    = 1'b0;
                capture_pos   = '0;
                push_tx(DEST_CAMERA, CAM_SYNC);
                push_tx(DEST_CAMERA, CAM_ZERO);
                push_tx(DEST_CAMERA, CAM_READ);
                push_tx(DEST_CAMERA, CAM_READ_LEN);
                push_tx(DEST_CAMERA, CAM_ZERO);
                push_tx(DEST_CAMERA, CAM_DELAY);
                repeat (6) push_tx(DEST_CAMERA, CAM_ZERO);
                push_tx(DEST_CAMERA, size_reply[LEN_HI_POS]);
                push_tx(DEST_CAMERA, size_reply[LEN_LO_POS]);
                push_tx(DEST_CAMERA, CAM_ZERO);
                push_tx(DEST_CAMERA, CAM_DELAY);
            end
        end
        if (step_bytes.size() != 0)
            step_bytes[step_bytes.size() - 1].last = 1'b1;
    endfunction

    // Offer one transfer from a falling edge; return at the falling edge after it is taken.
    // Typed rows replace the predicted final byte with the one written in the table.
    task automatic offer(input logic req, input logic [7:0] rx, input bit typed = 1'b0,
                         input int tcnt = 0, input logic tdest = DEST_CAMERA,
                         input logic [7:0] ttail = 8'h00);
        int n;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (o_in_stall);
        sequencer_step(req, rx);
        n = step_bytes.size();
        if (typed) begin
            if (n != tcnt) begin
                report_mismatch("result count of table row", 8'(n), 8'(tcnt));
            end else if (n > 0) begin
                step_bytes[n - 1].dest = tdest;
                step_bytes[n - 1].data = ttail;
            end
        end
        foreach (step_bytes[k]) expected_tx.push_back(step_bytes[k]);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Mostly uniform, with the start and end marker bytes weighted up
    function automatic logic [7:0] camera_byte();
        case ($urandom_range(9))
            0:       camera_byte = JPEG_START;
            1:       camera_byte = JPEG_END_HI;
            2:       camera_byte = JPEG_END_LO;
            default: camera_byte = 8'($urandom_range(255));
        endcase
    endfunction

    // Random traffic: mostly whole capture sequences with random content and the odd
    // restart mid-way, the rest bursts of loose bytes and triggers
    task automatic random_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned k;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 75) begin
                offer(REQ_TRIGGER, 8'($urandom_range(255)));
                for (k = 0; k < IDLE_REPLIES + SHOT_REPLIES + SIZE_REPLY_LEN; k++) begin
                    // restarting while armed lets idle and shot replies fill the store
                    if ($urandom_range(99) < 4)
                        offer(REQ_TRIGGER, 8'($urandom_range(255)));
                    offer(REQ_BYTE, camera_byte());
                end
                repeat ($urandom_range(2)) offer(REQ_BYTE, 8'($urandom_range(254)));
                offer(REQ_BYTE, JPEG_START);
                repeat ($urandom_range(1, 8)) offer(REQ_BYTE, camera_byte());
                if ($urandom_range(3) != 0) begin
                    offer(REQ_BYTE, JPEG_END_HI);
                    offer(REQ_BYTE, JPEG_END_LO);
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    offer(($urandom_range(7) == 0) ? REQ_TRIGGER : REQ_BYTE, camera_byte());
            end
        end
    endtask

    // Receiver: stall at random, or hold off for a long stretch when asked
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Check every output transfer against the oldest expected byte
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_tx.size() == 0) begin
                report_mismatch("unexpected byte", o_out_byte, 8'h00);
            end else begin
                t_tx want;
                want = expected_tx.pop_front();
                if (o_dest !== want.dest)
                    report_mismatch("dest", 8'(o_dest), 8'(want.dest));
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", o_out_byte, want.data);
                if (o_last !== want.last)
                    report_mismatch("last", 8'(o_last), 8'(want.last));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL serial_camera_capture_sequencer");
            $finish;
        end
    end

    initial begin
        int unsigned send_pct [4];
        int unsigned stall_pct [4];

        send_pct  = '{0, 71, 0, 29};
        stall_pct = '{0, 0, 71, 29};

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_req_type  = REQ_BYTE;
        i_rx_byte   = 8'h00;
        i_out_stall = 1'b0;
        items_sent    = 0;
        mismatches    = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        hold_left     = 0;
        hold_req      = 1'b0;
        hold_ack      = 1'b0;

        // predictor starts from the reset state
        cam_phase        = PH_NONE;
        idle_reply_count = '0;
        shot_reply_count = '0;
        size_cnt         = '0;
        capture_on       = 1'b0;
        capture_pos      = '0;
        image_read_on    = 1'b0;
        image_open       = 1'b0;
        end_hi_seen      = 1'b0;
        clear_size_reply();

        // hold reset, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, with no idling on either side
        foreach (directed_rows[r])
            offer(directed_rows[r].req, directed_rows[r].rx, directed_rows[r].typed,
                  int'(directed_rows[r].cnt), directed_rows[r].dest, directed_rows[r].tail);

        // random part across the idling mixes
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pct[p];
            rx_stall_pct  = stall_pct[p];
            random_traffic(30);
        end

        // back-pressure: the receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        hold_req      = ~hold_req;
        random_traffic(30);

        // pause the sender until every owed byte has arrived, then carry on
        i_in_valid <= 1'b0;
        while (expected_tx.size() != 0) @(negedge i_clk);
        rx_stall_pct = 29;
        random_traffic(20);

        i_in_valid <= 1'b0;
        while (expected_tx.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0)
            $display("PASS serial_camera_capture_sequencer");
        else
            $display("FAIL serial_camera_capture_sequencer");
        $finish;
    end

endmodule

### serial_camera_capture_sequencer.f
hw/rtl/scc_pkg.sv
hw/rtl/scc_ctrl.sv
hw/rtl/scc_emit.sv
hw/rtl/serial_camera_capture_sequencer.sv
verif/serial_camera_capture_sequencer_tb.sv
